// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the point encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/tspe_pkg.sv
// Package with types and constants of the time-series point encoder.
`default_nettype none

package tspe_pkg;

    localparam int WORD_W     = 64;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = WORD_W / DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int GROUP_W    = 7;
    localparam int BYTE_W     = 8;

    localparam logic PART_TIME  = 1'b0;
    localparam logic PART_VALUE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT_TS,
        ST_EMIT_VAL
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/timeseries_point_encoder.sv
// Top level of the time-series point encoder: delta-of-delta, zigzag and varint output.
`default_nettype none

// Encodes one point (64-bit timestamp, 64 raw value bits) per input item into a
// stream of LEB128 varint bytes, one byte per output item. The timestamp field
// comes first: while the stored time is zero the raw timestamp is sent, else the
// zigzag-mapped delta of delta (modulo 2^64). The value field follows as the XOR
// of the value bits with the previous point's value bits; its final byte carries
// last_of_point. An item is accepted first; then the two chained 64-bit
// subtractions run one 8-bit digit per cycle through rotating shift registers
// (skipped while the stored time is zero); then the emitted bytes, from 2 to 20
// per item, leave one per cycle through the single output byte register while
// the receiver does not stall it.
// A byte left waiting in the output register does not keep a new item out.
module timeseries_point_encoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] timestamp,
    input  wire logic [63:0] value_bits,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             part,
    output logic             last_of_point
);

    `include "assert_macros.svh"

    localparam int W  = tspe_pkg::WORD_W;
    localparam int D  = tspe_pkg::DIGIT_W;
    localparam int G  = tspe_pkg::GROUP_W;
    localparam int CW = tspe_pkg::CNT_W;

    // Control state
    tspe_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             b1_reg, b1_next;
    logic             b2_reg, b2_next;
    logic             out_valid_reg, out_valid_next;

    // Point state and working words
    logic [W-1:0] ts_reg, ts_next;
    logic [W-1:0] lt_reg, lt_next;
    logic [W-1:0] ld_reg, ld_next;
    logic [W-1:0] lv_reg, lv_next;
    logic [W-1:0] delta_reg, delta_next;
    logic [W-1:0] dod_reg, dod_next;
    logic [W-1:0] word_reg, word_next;
    logic [W-1:0] val_reg, val_next;

    // Output byte register
    logic [tspe_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                        part_reg, part_next;
    logic                        last_reg, last_next;

    // Datapath helpers
    logic         in_fire;
    logic         slot_free;
    logic         calc_last;
    logic         emit_go;
    logic         lt_zero;
    logic         more;
    logic [D:0]   diff1;
    logic [D:0]   diff2;
    logic [W-1:0] delta_full;
    logic [W-1:0] dod_full;
    logic [W-1:0] zigzag;

    // Handshake and sequencing outputs
    always_comb
    begin
        in_ready  = (state_reg == tspe_pkg::ST_IDLE);
        in_fire   = in_valid && in_ready;
        slot_free = !out_valid_reg || out_ready;
        calc_last = (state_reg == tspe_pkg::ST_CALC) &&
                    (cnt_reg == CW'(tspe_pkg::NUM_DIGITS - 1));
        emit_go   = ((state_reg == tspe_pkg::ST_EMIT_TS) ||
                     (state_reg == tspe_pkg::ST_EMIT_VAL)) && slot_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tspe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = lt_zero ? tspe_pkg::ST_EMIT_TS : tspe_pkg::ST_CALC;
                end
            end
            tspe_pkg::ST_CALC:
            begin
                if (calc_last)
                begin
                    state_next = tspe_pkg::ST_EMIT_TS;
                end
            end
            tspe_pkg::ST_EMIT_TS:
            begin
                if (emit_go && !more)
                begin
                    state_next = tspe_pkg::ST_EMIT_VAL;
                end
            end
            tspe_pkg::ST_EMIT_VAL:
            begin
                if (emit_go && !more)
                begin
                    state_next = tspe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tspe_pkg::ST_IDLE;
            end
        endcase
    end

    // One 8-bit digit of delta = ts - last_time and dod = delta - last_delta
    always_comb
    begin
        lt_zero    = ~|lt_reg;
        diff1      = {1'b0, ts_reg[D-1:0]} - {1'b0, lt_reg[D-1:0]} - {{D{1'b0}}, b1_reg};
        diff2      = {1'b0, diff1[D-1:0]} - {1'b0, ld_reg[D-1:0]} - {{D{1'b0}}, b2_reg};
        delta_full = {diff1[D-1:0], delta_reg[W-1:D]};
        dod_full   = {diff2[D-1:0], dod_reg[W-1:D]};
        // Zigzag: shift left, flip all bits when negative
        zigzag     = {dod_full[W-2:0], 1'b0} ^ {W{dod_full[W-1]}};
        // More groups follow while anything is left above the low seven bits
        more       = |word_reg[W-1:G];
    end

    // Datapath next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        ts_next        = ts_reg;
        lt_next        = lt_reg;
        ld_next        = ld_reg;
        lv_next        = lv_reg;
        delta_next     = delta_reg;
        dod_next       = dod_reg;
        word_next      = word_reg;
        val_next       = val_reg;
        out_byte_next  = out_byte_reg;
        part_next      = part_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tspe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    ts_next  = timestamp;
                    val_next = value_bits ^ lv_reg;
                    lv_next  = value_bits;
                    cnt_next = '0;
                    b1_next  = 1'b0;
                    b2_next  = 1'b0;
                    if (lt_zero)
                    begin
                        // Raw timestamp; last delta stays as it is
                        word_next = timestamp;
                        lt_next   = timestamp;
                    end
                end
            end
            tspe_pkg::ST_CALC:
            begin
                // Rotate operands one digit; they come back whole after a full pass
                ts_next    = {ts_reg[D-1:0], ts_reg[W-1:D]};
                lt_next    = {lt_reg[D-1:0], lt_reg[W-1:D]};
                ld_next    = {ld_reg[D-1:0], ld_reg[W-1:D]};
                delta_next = delta_full;
                dod_next   = dod_full;
                b1_next    = diff1[D];
                b2_next    = diff2[D];
                cnt_next   = cnt_reg + CW'(1);
                if (calc_last)
                begin
                    lt_next   = {ts_reg[D-1:0], ts_reg[W-1:D]};
                    ld_next   = delta_full;
                    word_next = zigzag;
                end
            end
            tspe_pkg::ST_EMIT_TS, tspe_pkg::ST_EMIT_VAL:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {more, word_reg[G-1:0]};
                    if (state_reg == tspe_pkg::ST_EMIT_TS)
                    begin
                        part_next = tspe_pkg::PART_TIME;
                        last_next = 1'b0;
                    end
                    else
                    begin
                        part_next = tspe_pkg::PART_VALUE;
                        last_next = !more;
                    end
                    // Advance one group, or hand over to the value field
                    if (more)
                    begin
                        word_next = {{G{1'b0}}, word_reg[W-1:G]};
                    end
                    else
                    begin
                        word_next = val_reg;
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control and stored point state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tspe_pkg::ST_IDLE;
            cnt_reg       <= '0;
            b1_reg        <= 1'b0;
            b2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            lt_reg        <= '0;
            ld_reg        <= '0;
            lv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            b1_reg        <= b1_next;
            b2_reg        <= b2_next;
            out_valid_reg <= out_valid_next;
            lt_reg        <= lt_next;
            ld_reg        <= ld_next;
            lv_reg        <= lv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ts_reg       <= ts_next;
        delta_reg    <= delta_next;
        dod_reg      <= dod_next;
        word_reg     <= word_next;
        val_reg      <= val_next;
        out_byte_reg <= out_byte_next;
        part_reg     <= part_next;
        last_reg     <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign part          = part_reg;
    assign last_of_point = last_reg;

    // A byte that promises more to follow never closes the point
    `ASSERT_IMP(a_cont_not_last, clk, rst_n, out_valid && out_byte[7], !last_of_point)
    // The closing byte of a point belongs to the value field
    `ASSERT_IMP(a_last_is_value, clk, rst_n, out_valid && last_of_point, part == tspe_pkg::PART_VALUE)
    // An accepted item goes straight into the subtract pass or the timestamp field
    `ASSERT_NXT(a_accept_moves, clk, rst_n, in_valid && in_ready, (state_reg == tspe_pkg::ST_CALC) || (state_reg == tspe_pkg::ST_EMIT_TS))
    // The final digit of the subtract pass hands over to the timestamp field
    `ASSERT_NXT(a_calc_done, clk, rst_n, calc_last, state_reg == tspe_pkg::ST_EMIT_TS)

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the time-series point encoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no item moving on either channel before the run is declared hung.
    // A point runs the subtract pass and sends up to 20 bytes, and each byte may wait
    // out a long receiver stall; the limit is far beyond any quiet stretch of a correct run.
    localparam int STALL_LIMIT    = 1000;
    // Settle time after the last byte: covers the subtract pass and output.
    localparam int DRAIN_CYCLES   = 40;
    localparam int RAND_PER_PHASE = 84;
    localparam int NUM_DIRECTED   = 20;

    // One expected output byte of the varint stream.
    typedef struct packed {
        logic [7:0] data;
        logic       fld;
        logic       last;
    } enc_byte_t;

    // One directed point; ts_word/val_word are the varint words typed in by hand
    // and only used where typed is set.
    typedef struct packed {
        logic [63:0] ts;
        logic [63:0] vb;
        logic        typed;
        logic [63:0] ts_word;
        logic [63:0] val_word;
    } point_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] timestamp;
    logic [63:0] value_bits;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        part;
    logic        last_of_point;

    // Encoder state as the block should hold it.
    logic [63:0] prev_time;
    logic [63:0] prev_delta;
    logic [63:0] prev_value;

    enc_byte_t   pending_bytes[$];
    point_row_t  dir_rows [0:NUM_DIRECTED-1];

    int errors        = 0;
    int points_sent   = 0;
    int raw_points    = 0;
    int bytes_checked = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    timeseries_point_encoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .timestamp     (timestamp),
        .value_bits    (value_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .part          (part),
        .last_of_point (last_of_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Advance the encoder state by one point and return the two field words:
    // the raw timestamp while no time is stored, else the zigzagged delta of delta.
    function automatic void point_words(input logic [63:0] ts, input logic [63:0] vb,
                                        output logic [63:0] ts_word,
                                        output logic [63:0] val_word);
        logic [63:0] delta;
        logic [63:0] dod;
        if (prev_time == 64'd0)
        begin
            ts_word = ts;
            raw_points++;
        end
        else
        begin
            delta      = ts - prev_time;
            dod        = delta - prev_delta;
            ts_word    = (dod << 1) ^ {64{dod[63]}};
            prev_delta = delta;
        end
        prev_time  = ts;
        val_word   = vb ^ prev_value;
        prev_value = vb;
    endfunction

    // Split a word into 7-bit groups, low group first, and queue the bytes.
    function automatic void push_varint(logic [63:0] word, logic fld, logic is_final);
        logic [63:0] rest;
        enc_byte_t   b;
        rest = word;
        while (rest >= 64'h80)
        begin
            b.data = {1'b1, rest[6:0]};
            b.fld  = fld;
            b.last = 1'b0;
            pending_bytes = {pending_bytes, b};
            rest = rest >> 7;
        end
        b.data = {1'b0, rest[6:0]};
        b.fld  = fld;
        b.last = is_final;
        pending_bytes = {pending_bytes, b};
    endfunction

    // Present one point, optionally after an idle gap, and queue its bytes once
    // accepted. Valid is left high on return; the next call either lowers it for
    // a gap or replaces the payload, so it gets one assignment per edge.
    task automatic send_point(input logic [63:0] ts, input logic [63:0] vb,
                              input logic typed, input logic [63:0] ts_typed,
                              input logic [63:0] val_typed);
        logic [63:0] tw;
        logic [63:0] vw;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        timestamp  <= ts;
        value_bits <= vb;
        do @(posedge clk); while (!in_ready);
        point_words(ts, vb, tw, vw);
        if (typed)
        begin
            tw = ts_typed;
            vw = val_typed;
        end
        push_varint(tw, tspe_pkg::PART_TIME, 1'b0);
        push_varint(vw, tspe_pkg::PART_VALUE, 1'b1);
        points_sent++;
    endtask

    // Output side: check every accepted byte against the oldest expectation,
    // then decide whether to stall the next cycle.
    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    report_mismatch("byte with nothing pending", 64'(out_byte), 64'd0);
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", 64'(out_byte), 64'(want.data));
                    if (part !== want.fld)
                        report_mismatch("part", 64'(part), 64'(want.fld));
                    if (last_of_point !== want.last)
                        report_mismatch("last_of_point", 64'(last_of_point),
                                        64'(want.last));
                end
                bytes_checked++;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
        begin
            out_ready <= 1'b0;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin : main
        logic [63:0] cur_ts;
        logic [63:0] cur_vb;
        logic [63:0] rnd;
        logic [63:0] step;
        int          kind;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        timestamp  = 64'd0;
        value_bits = 64'd0;
        prev_time  = 64'd0;
        prev_delta = 64'd0;
        prev_value = 64'd0;

        // Directed points. Typed rows carry their varint words read straight off
        // the encoding rules; the others go through the predictor.
        dir_rows = '{
            // zero stored time: raw timestamps, zero words give one byte each
            '{64'd0, 64'd0, 1'b1, 64'd0, 64'd0},
            '{64'd0, '1, 1'b1, 64'd0, '1},
            '{64'd1, '1, 1'b1, 64'd1, 64'd0},
            // backward wrap: delta = -2, dod = -2, zigzag gives 3
            '{'1, 64'd0, 1'b1, 64'd3, '1},
            // forward wrap to zero: delta = 1, dod = 3, zigzag gives 6; time goes raw again
            '{64'd0, 64'h8000_0000_0000_0000, 1'b1, 64'd6, 64'h8000_0000_0000_0000},
            '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_007F, 1'b1,
              64'h8000_0000_0000_0000, 64'h7F},
            // steady step: dod of zero; value word just over one byte
            '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_00FF, 1'b1, 64'd0, 64'h80},
            '{64'h8000_0000_0000_0003, 64'h8000_0000_0000_3FFF, 1'b0, 64'd0, 64'd0},
            '{64'h8000_0000_0000_0002, 64'h8000_0000_0000_4000, 1'b0, 64'd0, 64'd0},
            '{64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_4000, 1'b0, 64'd0, 64'd0},
            '{64'h0000_0000_0000_0080, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0, 64'd0},
            '{64'h0000_0000_0000_0100, 64'hFEDC_BA98_7654_3210, 1'b0, 64'd0, 64'd0},
            '{64'h0000_0000_0000_0180, 64'hFEDC_BA98_7654_3210, 1'b0, 64'd0, 64'd0},
            '{64'hFFFF_FFFF_FFFF_FF00, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 64'd0},
            '{64'h0000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 64'd0},
            '{64'h4000_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b0, 64'd0, 64'd0},
            '{64'hC000_0000_0000_0000, 64'hFFF8_0000_0000_0000, 1'b0, 64'd0, 64'd0},
            // a zero timestamp keeps the next point raw as well
            '{64'd0, 64'h3FF0_0000_0000_0000, 1'b0, 64'd0, 64'd0},
            '{64'd0, 64'h3FF0_0000_0000_0000, 1'b0, 64'd0, 64'd0},
            '{64'h0000_0000_3B9A_CA00, 64'h4009_21FB_5444_2D18, 1'b0, 64'd0, 64'd0}
        };

        send_idle_pct = 33;
        recv_idle_pct = 77;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_point(dir_rows[i].ts, dir_rows[i].vb, dir_rows[i].typed,
                       dir_rows[i].ts_word, dir_rows[i].val_word);
        end

        // Random points in three stall mixes. Most are well-formed series: a
        // steady step with jitter and slowly drifting value bits, which is what
        // exercises the delta-of-delta path. The rest restart the series or are noise.
        cur_ts = dir_rows[NUM_DIRECTED-1].ts;
        cur_vb = dir_rows[NUM_DIRECTED-1].vb;
        step   = 64'd1000;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 33;
                    // Hold off the sender until the encoder has drained completely.
                    in_valid <= 1'b0;
                    do @(posedge clk); while (pending_bytes.size() != 0);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                kind = $urandom_range(99);
                rnd  = {$urandom, $urandom};
                if ($urandom_range(15) == 0)
                    step = 64'($urandom_range(1, 100000)) << $urandom_range(30);
                if (kind < 70)
                begin
                    cur_ts = cur_ts + step + 64'($urandom_range(4)) - 64'd2;
                    cur_vb = cur_vb ^ ((rnd >> $urandom_range(63)) << $urandom_range(63));
                end
                else if (kind < 75)
                begin
                    cur_ts = 64'd0;
                    cur_vb = rnd;
                end
                else if (kind < 80)
                begin
                    cur_ts = rnd;
                end
                else
                begin
                    cur_ts = {$urandom, $urandom};
                    cur_vb = rnd;
                end
                send_point(cur_ts, cur_vb, 1'b0, 64'd0, 64'd0);
            end
        end

        // Drop valid and wait for every expected byte, then let the pipeline settle.
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_bytes.size() != 0)
            report_mismatch("bytes never emitted", 64'(pending_bytes.size()), 64'd0);

        $display("Covered %0d points (%0d directed, rest random), %0d of them sent raw.",
                 points_sent, NUM_DIRECTED, raw_points);
        $display("Checked %0d bytes over three stall mixes with %0d mismatches.",
                 bytes_checked, errors);
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tspe_pkg.sv
rtl/core/timeseries_point_encoder.sv
tb/sv/tb.sv
